### rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
package rbsi_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int EPS_W   = 16;
    localparam int DIST_W  = 31;
    localparam int NUM_AXES = 3;

    // lane stages: operand capture, overflow check, one per quotient bit, sort
    localparam int LANE_DEPTH = COORD_W + 2;

    localparam logic [63:0] DIST_MAX = 64'h0000_0000_7FFF_FFFF;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [EPS_W-1:0]          eps_t;
    typedef logic [DIST_W-1:0]         dist_t;

    typedef struct packed {
        logic   par;
        logic   par_miss;
        coord_t t_near;
        coord_t t_far;
    } lane_res_t;

endpackage

### rtl/rbsi_lane.sv
`timescale 1ns / 1ps
module rbsi_lane (
    input  logic              clk,
    input  logic              adv,
    input  rbsi_pkg::coord_t  org,
    input  rbsi_pkg::coord_t  dir,
    input  rbsi_pkg::coord_t  lo,
    input  rbsi_pkg::coord_t  hi,
    input  rbsi_pkg::eps_t    eps,
    output rbsi_pkg::lane_res_t res
);
    import rbsi_pkg::*;

    localparam int QW = COORD_W - 1;
    localparam int NW = COORD_W + FRAC_W;

    typedef struct packed {
        logic [COORD_W-1:0] rem;
        logic [QW-1:0]      nlow;
        logic [QW-1:0]      q;
        logic               ovf;
    } div_t;

    typedef struct packed {
        logic [COORD_W-1:0] dmag;
        logic               neg_a;
        logic               neg_b;
        logic               par;
        logic               par_miss;
    } side_t;

    // capture stage
    logic [COORD_W-1:0] na_reg, nb_reg;
    side_t              s0_reg;

    logic signed [COORD_W:0] diff_a, diff_b;
    logic signed [COORD_W:0] neg_diff_a, neg_diff_b;
    logic [COORD_W-1:0]      dmag_c;
    side_t                   s0_next;

    always_comb
    begin
        diff_a     = (COORD_W+1)'(lo) - (COORD_W+1)'(org);
        diff_b     = (COORD_W+1)'(hi) - (COORD_W+1)'(org);
        neg_diff_a = -diff_a;
        neg_diff_b = -diff_b;
        dmag_c     = dir[COORD_W-1] ? COORD_W'(-dir) : COORD_W'(dir);
        s0_next.dmag     = dmag_c;
        s0_next.neg_a    = diff_a[COORD_W] ^ dir[COORD_W-1];
        s0_next.neg_b    = diff_b[COORD_W] ^ dir[COORD_W-1];
        s0_next.par      = dmag_c <= COORD_W'(eps);
        s0_next.par_miss = (org < lo) || (org > hi);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na_reg <= diff_a[COORD_W] ? COORD_W'(neg_diff_a) : COORD_W'(diff_a);
            nb_reg <= diff_b[COORD_W] ? COORD_W'(neg_diff_b) : COORD_W'(diff_b);
            s0_reg <= s0_next;
        end
    end

    // divider stages 1..COORD_W
    div_t  da_reg [1:COORD_W];
    div_t  db_reg [1:COORD_W];
    side_t sd_reg [1:COORD_W];

    function automatic div_t div_init(input logic [COORD_W-1:0] n,
                                      input logic [COORD_W-1:0] d);
        logic [NW-1:0] nn;
        logic [NW-1:0] top;
        div_t          r;
        nn    = {n, {FRAC_W{1'b0}}};
        top   = nn >> QW;
        r.ovf = top >= NW'(d);
        r.rem = COORD_W'(top);
        r.nlow = nn[QW-1:0];
        r.q   = '0;
        return r;
    endfunction

    function automatic div_t div_step(input div_t s, input logic [COORD_W-1:0] d);
        logic [COORD_W-1:0] sh;
        logic               bit_q;
        div_t               r;
        sh    = {s.rem[QW-1:0], s.nlow[QW-1]};
        bit_q = sh >= d;
        r.rem = bit_q ? sh - d : sh;
        r.nlow = s.nlow << 1;
        r.q   = {s.q[QW-2:0], bit_q};
        r.ovf = s.ovf;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            da_reg[1] <= div_init(na_reg, s0_reg.dmag);
            db_reg[1] <= div_init(nb_reg, s0_reg.dmag);
            sd_reg[1] <= s0_reg;
        end
    end

    genvar k;
    generate
        for (k = 1; k < COORD_W; k++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    da_reg[k+1] <= div_step(da_reg[k], sd_reg[k].dmag);
                    db_reg[k+1] <= div_step(db_reg[k], sd_reg[k].dmag);
                    sd_reg[k+1] <= sd_reg[k];
                end
            end
        end
    endgenerate

    // saturate, sign and sort
    function automatic coord_t finish(input div_t s, input logic neg);
        logic [QW-1:0] mag;
        coord_t        v;
        mag = s.ovf ? {QW{1'b1}} : s.q;
        v   = coord_t'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    coord_t    ta, tb;
    lane_res_t res_next, res_reg;

    always_comb
    begin
        ta = finish(da_reg[COORD_W], sd_reg[COORD_W].neg_a);
        tb = finish(db_reg[COORD_W], sd_reg[COORD_W].neg_b);
        res_next.par      = sd_reg[COORD_W].par;
        res_next.par_miss = sd_reg[COORD_W].par_miss;
        res_next.t_near   = (ta > tb) ? tb : ta;
        res_next.t_far    = (ta > tb) ? ta : tb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/rbsi_merge.sv
`timescale 1ns / 1ps
module rbsi_merge (
    input  rbsi_pkg::lane_res_t lane_x,
    input  rbsi_pkg::lane_res_t lane_y,
    input  rbsi_pkg::lane_res_t lane_z,
    output logic                hit,
    output rbsi_pkg::dist_t     distance
);
    import rbsi_pkg::*;

    lane_res_t   lanes [NUM_AXES];
    logic        have, miss;
    coord_t      tmin, tmax;
    logic [63:0] tmin_w;

    always_comb
    begin
        lanes[0] = lane_x;
        lanes[1] = lane_y;
        lanes[2] = lane_z;
        have = 1'b0;
        miss = 1'b0;
        tmin = '0;
        tmax = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (!miss)
            begin
                if (lanes[i].par)
                begin
                    if (lanes[i].par_miss)
                        miss = 1'b1;
                end
                else if (have && (tmin > lanes[i].t_far || lanes[i].t_near > tmax))
                begin
                    miss = 1'b1;
                end
                else
                begin
                    if (!have || lanes[i].t_near > tmin)
                        tmin = lanes[i].t_near;
                    if (!have || lanes[i].t_far < tmax)
                        tmax = lanes[i].t_far;
                    have = 1'b1;
                end
            end
        end

        tmin_w   = 64'(unsigned'(tmin));
        hit      = 1'b0;
        distance = '0;
        if (!miss && have)
        begin
            if (tmin < 0)
            begin
                hit = tmax > 0;
            end
            else
            begin
                hit      = 1'b1;
                distance = (tmin_w > DIST_MAX) ? DIST_W'(DIST_MAX) : tmin_w[DIST_W-1:0];
            end
        end
    end

endmodule

### rtl/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake           | Payload
// in       | in  | in_valid/in_stall   | origin_*, dir_*, box_min_*, box_max_*
// out      | out | out_valid/out_stall | hit, distance
// cfg      | in  | cfg_wen             | cfg_wdata (direction_epsilon)
//
// One word per cycle sustained while in_stall is low; each word passes the
// operand capture stage, the bit-per-stage quotient pipelines in each axis lane,
// the sort stage and then the output register.
// Reset clears the valid chain, the output and skid valid flags and the epsilon.
// A stalled output holds one word; a second finished word parks in the skid
// register and then in_stall rises until the output drains.
module ray_box_slab_intersect (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wen,
    input  rbsi_pkg::eps_t   cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  rbsi_pkg::coord_t origin_x,
    input  rbsi_pkg::coord_t origin_y,
    input  rbsi_pkg::coord_t origin_z,
    input  rbsi_pkg::coord_t dir_x,
    input  rbsi_pkg::coord_t dir_y,
    input  rbsi_pkg::coord_t dir_z,
    input  rbsi_pkg::coord_t box_min_x,
    input  rbsi_pkg::coord_t box_min_y,
    input  rbsi_pkg::coord_t box_min_z,
    input  rbsi_pkg::coord_t box_max_x,
    input  rbsi_pkg::coord_t box_max_y,
    input  rbsi_pkg::coord_t box_max_z,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             hit,
    output rbsi_pkg::dist_t  distance
);
    import rbsi_pkg::*;

    eps_t eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= '0;
        else if (cfg_wen)
            eps_reg <= cfg_wdata;
    end

    logic                  adv;
    logic [LANE_DEPTH-1:0] vld_reg;

    logic  out_valid_reg, skid_valid_reg;
    logic  out_hit_reg, skid_hit_reg;
    dist_t out_dist_reg, skid_dist_reg;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LANE_DEPTH-2:0], in_valid};
    end

    lane_res_t res_x, res_y, res_z;

    rbsi_lane u_lane_x (
        .clk(clk), .adv(adv), .org(origin_x), .dir(dir_x),
        .lo(box_min_x), .hi(box_max_x), .eps(eps_reg), .res(res_x)
    );

    rbsi_lane u_lane_y (
        .clk(clk), .adv(adv), .org(origin_y), .dir(dir_y),
        .lo(box_min_y), .hi(box_max_y), .eps(eps_reg), .res(res_y)
    );

    rbsi_lane u_lane_z (
        .clk(clk), .adv(adv), .org(origin_z), .dir(dir_z),
        .lo(box_min_z), .hi(box_max_z), .eps(eps_reg), .res(res_z)
    );

    logic  m_hit;
    dist_t m_dist;

    rbsi_merge u_merge (
        .lane_x(res_x), .lane_y(res_y), .lane_z(res_z),
        .hit(m_hit), .distance(m_dist)
    );

    logic incoming;
    assign incoming = vld_reg[LANE_DEPTH-1] && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg  <= skid_valid_reg || incoming;
            skid_valid_reg <= 1'b0;
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // advance the output word, park into skid while held
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_hit_reg  <= skid_valid_reg ? skid_hit_reg : m_hit;
            out_dist_reg <= skid_valid_reg ? skid_dist_reg : m_dist;
        end
        else if (incoming)
        begin
            skid_hit_reg  <= m_hit;
            skid_dist_reg <= m_dist;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign distance  = out_dist_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (out_dist_reg == '0))
        else $error("miss with nonzero distance");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled while output free");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rbsi_pkg::*;

    typedef struct {
        coord_t org [3];
        coord_t dir [3];
        coord_t bmin [3];
        coord_t bmax [3];
    } ray_box_t;

    typedef struct {
        logic  hit;
        dist_t dist_val;
    } slab_res_t;

    localparam longint T_SAT = 64'h7FFF_FFFF;
    localparam int LAT = COORD_W + 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    eps_t cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    coord_t origin_x = '0, origin_y = '0, origin_z = '0;
    coord_t dir_x = '0, dir_y = '0, dir_z = '0;
    coord_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
    coord_t box_max_x = '0, box_max_y = '0, box_max_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    dist_t distance;

    ray_box_t pending_rays [$];
    slab_res_t expected_hits [$];
    eps_t eps_shadow = '0;
    int errors = 0;
    longint cycle_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    bit drive_on = 1'b0;
    bit rand_gaps = 1'b0;

    always #5 clk = ~clk;

    ray_box_slab_intersect i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .distance(distance)
    );

    function automatic longint slab_time(longint num, longint den);
        longint n, d, ip, r, q;
        bit neg;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        ip = n / d;
        r = n % d;
        if (ip > T_SAT)
            q = T_SAT;
        else
        begin
            q = ip;
            for (int i = 0; i < FRAC_W; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
            if (q > T_SAT)
                q = T_SAT;
        end
        return neg ? -q : q;
    endfunction

    function automatic slab_res_t intersect_box(ray_box_t rb, eps_t eps);
        slab_res_t res;
        bit have, miss;
        longint tmin, tmax, o, d, lo, hi, a, b, t;
        have = 0;
        miss = 0;
        tmin = 0;
        tmax = 0;
        res.hit = 1'b0;
        res.dist_val = '0;
        for (int ax = 0; ax < NUM_AXES; ax++)
        begin
            if (!miss)
            begin
                o = rb.org[ax];
                d = rb.dir[ax];
                lo = rb.bmin[ax];
                hi = rb.bmax[ax];
                if ((d < 0 ? -d : d) <= longint'(eps))
                begin
                    if (o < lo || o > hi)
                        miss = 1;
                end
                else
                begin
                    a = slab_time(lo - o, d);
                    b = slab_time(hi - o, d);
                    if (a > b)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    if (have && (tmin > b || a > tmax))
                        miss = 1;
                    else
                    begin
                        if (!have || a > tmin)
                            tmin = a;
                        if (!have || b < tmax)
                            tmax = b;
                        have = 1;
                    end
                end
            end
        end
        if (miss || !have)
            return res;
        if (tmin < 0)
        begin
            res.hit = tmax > 0;
            return res;
        end
        res.hit = 1'b1;
        res.dist_val = dist_t'(tmin > T_SAT ? T_SAT : tmin);
        return res;
    endfunction

    function automatic int gap_len();
        if (!rand_gaps)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            expected_hits.push_back(intersect_box(pending_rays.pop_front(), eps_shadow));
            send_gap <= gap_len();
        end
        if (in_valid && in_stall)
            ;
        else if (drive_on && pending_rays.size() > 0 && send_gap == 0
                 && !(in_valid && !in_stall && pending_rays.size() == 0))
        begin
            in_valid <= 1'b1;
            origin_x <= pending_rays[0].org[0];
            origin_y <= pending_rays[0].org[1];
            origin_z <= pending_rays[0].org[2];
            dir_x <= pending_rays[0].dir[0];
            dir_y <= pending_rays[0].dir[1];
            dir_z <= pending_rays[0].dir[2];
            box_min_x <= pending_rays[0].bmin[0];
            box_min_y <= pending_rays[0].bmin[1];
            box_min_z <= pending_rays[0].bmin[2];
            box_max_x <= pending_rays[0].bmax[0];
            box_max_y <= pending_rays[0].bmax[1];
            box_max_z <= pending_rays[0].bmax[2];
        end
        else
        begin
            in_valid <= 1'b0;
            if (send_gap > 0 && !(in_valid && !in_stall))
                send_gap <= send_gap - 1;
        end
    end

    // monitor and receiver
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected word hit=%0b distance=%h", $time, hit, distance);
                errors++;
            end
            else
            begin
                if (hit !== expected_hits[0].hit)
                begin
                    $display("%0t: hit expected %0b actual %0b",
                             $time, expected_hits[0].hit, hit);
                    errors++;
                end
                if (distance !== expected_hits[0].dist_val)
                begin
                    $display("%0t: distance expected %h actual %h",
                             $time, expected_hits[0].dist_val, distance);
                    errors++;
                end
                void'(expected_hits.pop_front());
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            recv_gap <= gap_len();
        end
        if (cycle_count > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return coord_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
            default: return coord_t'($signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic ray_box_t make_ray(bit aimed);
        ray_box_t rb;
        coord_t p, q;
        for (int ax = 0; ax < 3; ax++)
        begin
            p = rand_coord();
            q = rand_coord();
            if (aimed && $urandom_range(0, 4) != 0 && p > q)
            begin
                rb.bmin[ax] = q;
                rb.bmax[ax] = p;
            end
            else
            begin
                rb.bmin[ax] = p;
                rb.bmax[ax] = q;
            end
            rb.org[ax] = rand_coord();
            case ($urandom_range(0, 6))
                0: rb.dir[ax] = coord_t'($signed($urandom_range(0, 64)) - 32);
                1: rb.dir[ax] = coord_t'($urandom);
                2: rb.dir[ax] = coord_t'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
                default: rb.dir[ax] = coord_t'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
            endcase
            if (aimed && $urandom_range(0, 1))
                rb.dir[ax] = coord_t'((longint'(rb.bmin[ax]) + longint'(rb.bmax[ax])) / 2
                                      - longint'(rb.org[ax])) >>> $urandom_range(0, 8);
        end
        return rb;
    endfunction

    function automatic ray_box_t unit_ray(coord_t o, coord_t d, coord_t lo, coord_t hi);
        ray_box_t rb;
        for (int ax = 0; ax < 3; ax++)
        begin
            rb.org[ax] = o;
            rb.dir[ax] = d;
            rb.bmin[ax] = lo;
            rb.bmax[ax] = hi;
        end
        return rb;
    endfunction

    task automatic drain_and_write(eps_t v);
        drive_on = 1'b1;
        wait (pending_rays.size() == 0 && !in_valid && expected_hits.size() == 0);
        repeat (LAT + 4) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        eps_shadow = v;
        @(posedge clk);
    endtask

    initial
    begin
        ray_box_t rb;
        eps_t eps_set [5] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h1234};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed
        pending_rays.push_back(unit_ray(32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0002_8000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0000_0000, 32'sh0000_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0002_8000, 32'sh0000_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pending_rays.push_back(unit_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
        pending_rays.push_back(unit_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_rays.push_back(unit_ray(32'sh0000_0000, -32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0002_8000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0002_0000));
        pending_rays.push_back(unit_ray(32'sh0000_0000, 32'sh0000_0003, 32'sh0000_0001, 32'sh0000_0007));
        pending_rays.push_back(unit_ray(32'shFFFF_FFFF, 32'sh0000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
        rb = unit_ray(32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0004_0000);
        rb.dir[1] = 32'sh0000_0000;
        rb.bmin[1] = -32'sh0001_0000;
        pending_rays.push_back(rb);
        rb.org[2] = 32'sh0009_0000;
        pending_rays.push_back(rb);
        drain_and_write(16'hFFFF);
        pending_rays.push_back(unit_ray(32'sh0000_0000, 32'sh0000_FFFF, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
        pending_rays.push_back(unit_ray(32'sh0000_0000, -32'sh0000_FFFF, -32'sh0002_0000, 32'sh0003_0000));
        rand_gaps = 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_write(eps_set[ph]);
            for (int k = 0; k < 270; k++)
                pending_rays.push_back(make_ray($urandom_range(0, 3) != 0));
            if (ph == 2)
            begin
                wait (pending_rays.size() < 240);
                hold_off = 300;
            end
        end
        drive_on = 1'b1;
        wait (pending_rays.size() == 0 && !in_valid && expected_hits.size() == 0);
        repeat (LAT + 10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
